// ===== rtl/core/abs_pkg.sv =====
// ----------------------------------------------------------------------------
// abs_pkg
// Types and fixed constants shared by the affine blit setup pipeline.
// ----------------------------------------------------------------------------
package abs_pkg;

  localparam int unsigned COEF_W = 32;
  localparam int unsigned SIZE_W = 15;
  localparam int unsigned DIM_W  = 31;
  // cofactor and determinant widths
  localparam int unsigned DET_W  = 65;
  localparam int unsigned QUO_W  = 33;

  // per-stage control travelling with the data
  typedef struct packed {
    logic vld;
    logic ok;
  } abs_ctl_t;

  // sign-aware magnitude of a determinant sized value
  function automatic logic [DET_W-1:0] abs_det(input logic signed [DET_W-1:0] v);
    abs_det = v[DET_W-1] ? DET_W'(-v) : DET_W'(v);
  endfunction

endpackage

// ===== rtl/core/abs_div.sv =====
// ----------------------------------------------------------------------------
// abs_div
// Pipelined restoring divider: one quotient bit per stage, unsigned magnitudes.
// The dividend is num * 2^SHIFT; only QW quotient bits are kept and an
// overflow flag records any quotient beyond them.
// ----------------------------------------------------------------------------
module abs_div #(
  parameter int unsigned NW    = 33,
  parameter int unsigned DW    = 65,
  parameter int unsigned SHIFT = 32,
  parameter int unsigned QW    = 33
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic          over
);
  localparam int unsigned TOT = NW + SHIFT;
  localparam int unsigned RW  = DW + 1;

  logic [TOT-1:0] dvd_r [TOT+1];
  logic [DW-1:0]  den_r [TOT+1];
  logic [RW-1:0]  rem_r [TOT+1];
  logic [QW-1:0]  q_r   [TOT+1];
  logic           ov_r  [TOT+1];

  always_comb begin
    dvd_r[0] = {num, {SHIFT{1'b0}}};
    den_r[0] = den;
    rem_r[0] = '0;
    q_r[0]   = '0;
    ov_r[0]  = 1'b0;
  end

  // one quotient bit per stage
  for (genvar i = 0; i < TOT; i++) begin : g_stage
    logic [RW-1:0] sh;
    logic          qb;
    assign sh = {rem_r[i][RW-2:0], dvd_r[i][TOT-1-i]};
    assign qb = (sh >= RW'(den_r[i]));
    always_ff @(posedge clk) begin
      if (en) begin
        dvd_r[i+1] <= dvd_r[i];
        den_r[i+1] <= den_r[i];
        rem_r[i+1] <= qb ? RW'(sh - RW'(den_r[i])) : sh;
        q_r[i+1]   <= {q_r[i][QW-2:0], qb};
        ov_r[i+1]  <= ov_r[i] | q_r[i][QW-1];
      end
    end
  end

  assign quo  = q_r[TOT];
  assign over = ov_r[TOT];
endmodule

// ===== rtl/core/abs_bbox.sv =====
// ----------------------------------------------------------------------------
// abs_bbox
// Corner mapping and bounding rectangle, three registered stages.
// ----------------------------------------------------------------------------
module abs_bbox #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [abs_pkg::COEF_W-1:0]    xx, xy, xt, yx, yy, yt,
  input  logic [abs_pkg::SIZE_W-1:0]           w, h,
  output logic signed [abs_pkg::COEF_W-1:0]    left, top,
  output logic [abs_pkg::DIM_W-1:0]            dw, dh,
  output logic                                 ok
);
  import abs_pkg::*;
  localparam int unsigned PW = 50;
  localparam int unsigned SW = 52;

  // stage 1: products
  logic signed [PW-1:0] pxw_r, pxh_r, pyw_r, pyh_r;
  logic signed [SW-1:0] xt1_r, yt1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      pxw_r <= PW'(xx * $signed({1'b0, w}));
      pxh_r <= PW'(xy * $signed({1'b0, h}));
      pyw_r <= PW'(yx * $signed({1'b0, w}));
      pyh_r <= PW'(yy * $signed({1'b0, h}));
      xt1_r <= SW'(xt);
      yt1_r <= SW'(yt);
    end
  end

  // stage 2: corners reduced to min and max
  logic signed [SW-1:0] x1, x2, x3, y1, y2, y3;
  logic signed [SW-1:0] minx_nxt, maxx_nxt, miny_nxt, maxy_nxt;
  logic signed [SW-1:0] minx_r, maxx_r, miny_r, maxy_r;
  always_comb begin
    x1 = xt1_r + SW'(pxw_r);
    x2 = xt1_r + SW'(pxh_r);
    x3 = x1 + SW'(pxh_r);
    y1 = yt1_r + SW'(pyw_r);
    y2 = yt1_r + SW'(pyh_r);
    y3 = y1 + SW'(pyh_r);
    minx_nxt = xt1_r; maxx_nxt = xt1_r;
    miny_nxt = yt1_r; maxy_nxt = yt1_r;
    if (x1 < minx_nxt) minx_nxt = x1;
    if (x2 < minx_nxt) minx_nxt = x2;
    if (x3 < minx_nxt) minx_nxt = x3;
    if (x1 > maxx_nxt) maxx_nxt = x1;
    if (x2 > maxx_nxt) maxx_nxt = x2;
    if (x3 > maxx_nxt) maxx_nxt = x3;
    if (y1 < miny_nxt) miny_nxt = y1;
    if (y2 < miny_nxt) miny_nxt = y2;
    if (y3 < miny_nxt) miny_nxt = y3;
    if (y1 > maxy_nxt) maxy_nxt = y1;
    if (y2 > maxy_nxt) maxy_nxt = y2;
    if (y3 > maxy_nxt) maxy_nxt = y3;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      minx_r <= minx_nxt; maxx_r <= maxx_nxt;
      miny_r <= miny_nxt; maxy_r <= maxy_nxt;
    end
  end

  // stage 3: floor/ceil, range and emptiness
  localparam int unsigned FW = SW - FRAC_BITS + 1;
  logic signed [FW-1:0] fx, fy, cx, cy, ddx, ddy;
  logic                 ok_nxt;
  logic signed [SW-1:0] negx, negy;
  always_comb begin
    negx = -maxx_r;
    negy = -maxy_r;
    fx   = FW'(minx_r >>> FRAC_BITS);
    fy   = FW'(miny_r >>> FRAC_BITS);
    cx   = FW'(-(negx >>> FRAC_BITS));
    cy   = FW'(-(negy >>> FRAC_BITS));
    ddx  = cx - fx;
    ddy  = cy - fy;
    ok_nxt = (fx >= -FW'(64'sh80000000)) && (fy >= -FW'(64'sh80000000)) &&
             (cx <= FW'(64'sh7FFFFFFF)) && (cy <= FW'(64'sh7FFFFFFF)) &&
             (ddx > 0) && (ddy > 0) &&
             (ddx <= FW'(64'sh7FFFFFFF)) && (ddy <= FW'(64'sh7FFFFFFF));
  end
  always_ff @(posedge clk) begin
    if (en) begin
      left <= COEF_W'(fx);
      top  <= COEF_W'(fy);
      dw   <= DIM_W'(ddx);
      dh   <= DIM_W'(ddy);
      ok   <= ok_nxt;
    end
  end
endmodule

// ===== rtl/core/affine_blit_setup_core.sv =====
// Throughput: one transfer per cycle while the output is not stalled; the 65-stage divider pipeline sets depth.
// A stall freezes every stage in place, so nothing is lost or repeated.
// Reset clears the stage valid bits only; payload registers are not reset.
// ----------------------------------------------------------------------------
// affine_blit_setup_core
// Affine inverse and destination bounding box, fully pipelined.
// ----------------------------------------------------------------------------
module affine_blit_setup_core #(
  parameter int unsigned FRAC_BITS       = 16,
  parameter int unsigned MAX_SOURCE_SIDE = 16384
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [abs_pkg::COEF_W-1:0]   in_fwd_xx, in_fwd_xy, in_fwd_xt,
  input  logic signed [abs_pkg::COEF_W-1:0]   in_fwd_yx, in_fwd_yy, in_fwd_yt,
  input  logic [abs_pkg::SIZE_W-1:0]          in_src_width, in_src_height,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_supported,
  output logic signed [abs_pkg::COEF_W-1:0]   out_dest_left, out_dest_top,
  output logic [abs_pkg::DIM_W-1:0]           out_dest_width, out_dest_height,
  output logic signed [abs_pkg::COEF_W-1:0]   out_inv_xx, out_inv_xy, out_inv_xt,
  output logic signed [abs_pkg::COEF_W-1:0]   out_inv_yx, out_inv_yy, out_inv_yt
);
  import abs_pkg::*;

  localparam int unsigned SH    = 2 * FRAC_BITS;
  localparam int unsigned DIVL  = QUO_W + SH;
  localparam int unsigned TAIL  = 3;
  localparam int unsigned DEPTH = 3 + DIVL + TAIL;
  localparam logic [DET_W-1:0] THR =
    (SH >= 23) ? (DET_W'(1) << (SH - 23)) : '0;

  // global advance: stall everything when the output is held
  logic en;
  logic [DEPTH-1:0] vld_r;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end
  assign out_valid = vld_r[DEPTH-1];

  // stage 1: determinant products, size checks
  logic signed [63:0] pa_r, pb_r;
  logic signed [COEF_W-1:0] c_xx1_r, c_xy1_r, c_yx1_r, c_yy1_r, c_xt1_r, c_yt1_r;
  logic sz_ok1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      pa_r <= 64'(in_fwd_xx * in_fwd_yy);
      pb_r <= 64'(in_fwd_xy * in_fwd_yx);
      c_xx1_r <= in_fwd_xx; c_xy1_r <= in_fwd_xy; c_yx1_r <= in_fwd_yx;
      c_yy1_r <= in_fwd_yy; c_xt1_r <= in_fwd_xt; c_yt1_r <= in_fwd_yt;
      sz_ok1_r <= (in_src_width != '0) && (in_src_height != '0) &&
                  (32'(in_src_width) <= 32'(MAX_SOURCE_SIDE)) &&
                  (32'(in_src_height) <= 32'(MAX_SOURCE_SIDE));
    end
  end

  // stage 2: determinant
  logic signed [DET_W-1:0] det2_r;
  logic signed [COEF_W-1:0] c_xx2_r, c_xy2_r, c_yx2_r, c_yy2_r, c_xt2_r, c_yt2_r;
  logic sz_ok2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      det2_r <= DET_W'(pa_r) - DET_W'(pb_r);
      c_xx2_r <= c_xx1_r; c_xy2_r <= c_xy1_r; c_yx2_r <= c_yx1_r;
      c_yy2_r <= c_yy1_r; c_xt2_r <= c_xt1_r; c_yt2_r <= c_yt1_r;
      sz_ok2_r <= sz_ok1_r;
    end
  end

  // stage 3: magnitudes and signs for the dividers
  logic [DET_W-1:0] adet3_r;
  logic [QUO_W-1:0] m_r [4];
  logic             ng_r [4];
  logic det_ok3_r, sz_ok3_r;
  logic signed [COEF_W-1:0] c_xt3_r, c_yt3_r;
  logic signed [QUO_W-1:0] cof [4];
  logic [DET_W-1:0] ad;
  always_comb begin
    cof[0] = QUO_W'(c_yy2_r);
    cof[1] = -QUO_W'(c_xy2_r);
    cof[2] = -QUO_W'(c_yx2_r);
    cof[3] = QUO_W'(c_xx2_r);
    ad = abs_det(det2_r);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      adet3_r   <= ad;
      det_ok3_r <= ad > THR;
      sz_ok3_r  <= sz_ok2_r;
      c_xt3_r   <= c_xt2_r;
      c_yt3_r   <= c_yt2_r;
      for (int i = 0; i < 4; i++) begin
        m_r[i]  <= cof[i][QUO_W-1] ? QUO_W'(-cof[i]) : cof[i];
        ng_r[i] <= cof[i][QUO_W-1] ^ det2_r[DET_W-1];
      end
    end
  end

  // bounding box runs alongside, delayed to match
  logic signed [COEF_W-1:0] bb_left, bb_top;
  logic [DIM_W-1:0] bb_w, bb_h;
  logic bb_ok;
  abs_bbox #(.FRAC_BITS(FRAC_BITS)) u_bbox (
    .clk(clk), .en(en),
    .xx(in_fwd_xx), .xy(in_fwd_xy), .xt(in_fwd_xt),
    .yx(in_fwd_yx), .yy(in_fwd_yy), .yt(in_fwd_yt),
    .w(in_src_width), .h(in_src_height),
    .left(bb_left), .top(bb_top), .dw(bb_w), .dh(bb_h), .ok(bb_ok)
  );

  localparam int unsigned BBD = DIVL;
  localparam int unsigned BBX = 2 * COEF_W + 2 * DIM_W + 1;
  logic [BBX-1:0] bbd_r [BBD];
  localparam int unsigned SDX = 2 * COEF_W + 2 + 4;
  logic [SDX-1:0] sd_r [DIVL];
  always_ff @(posedge clk) begin
    if (en) begin
      bbd_r[0] <= {bb_left, bb_top, bb_w, bb_h, bb_ok};
      sd_r[0]  <= {c_xt3_r, c_yt3_r, det_ok3_r, sz_ok3_r,
                   ng_r[0], ng_r[1], ng_r[2], ng_r[3]};
      for (int i = 1; i < BBD; i++) begin
        bbd_r[i] <= bbd_r[i-1];
        sd_r[i]  <= sd_r[i-1];
      end
    end
  end

  // four dividers
  logic [QUO_W-1:0] q [4];
  logic             qo [4];
  for (genvar g = 0; g < 4; g++) begin : g_div
    abs_div #(.NW(QUO_W), .DW(DET_W), .SHIFT(SH), .QW(QUO_W)) u_div (
      .clk(clk), .en(en), .num(m_r[g]), .den(adet3_r), .quo(q[g]), .over(qo[g])
    );
  end

  // tail stage 1: sign and range of the linear terms
  logic signed [COEF_W-1:0] t_r [4];
  logic lin_ok_r, base_ok_r;
  logic signed [COEF_W-1:0] xt_t_r, yt_t_r;
  logic [BBX-1:0] bb_t1_r;
  logic lin_ok;
  logic [3:0] ngd;
  always_comb begin
    ngd = sd_r[DIVL-1][3:0];
    lin_ok = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (qo[i]) lin_ok = 1'b0;
      if (ngd[3-i] && q[i] > QUO_W'(33'h80000000)) lin_ok = 1'b0;
      if (!ngd[3-i] && q[i] > QUO_W'(33'h7FFFFFFF)) lin_ok = 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++)
        t_r[i] <= ngd[3-i] ? COEF_W'(-q[i]) : COEF_W'(q[i]);
      lin_ok_r  <= lin_ok;
      base_ok_r <= sd_r[DIVL-1][5] && sd_r[DIVL-1][4];
      xt_t_r    <= sd_r[DIVL-1][SDX-1 -: COEF_W];
      yt_t_r    <= sd_r[DIVL-1][SDX-1-COEF_W -: COEF_W];
      bb_t1_r   <= bbd_r[BBD-1];
    end
  end

  // tail stage 2: translation products
  logic signed [63:0] p_r [4];
  logic signed [COEF_W-1:0] t2_r [4];
  logic ok_t2_r;
  logic [BBX-1:0] bb_t2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= 64'(t_r[0] * xt_t_r);
      p_r[1] <= 64'(t_r[1] * yt_t_r);
      p_r[2] <= 64'(t_r[2] * xt_t_r);
      p_r[3] <= 64'(t_r[3] * yt_t_r);
      t2_r    <= t_r;
      ok_t2_r <= lin_ok_r && base_ok_r && bb_t1_r[0];
      bb_t2_r <= bb_t1_r;
    end
  end

  // tail stage 3: sums, floor shift, final gating
  logic signed [65:0] sx, sy, fxs, fys;
  logic fin_ok;
  always_comb begin
    sx  = -66'(p_r[0]) - 66'(p_r[1]);
    sy  = -66'(p_r[2]) - 66'(p_r[3]);
    fxs = sx >>> FRAC_BITS;
    fys = sy >>> FRAC_BITS;
    fin_ok = ok_t2_r &&
             fxs >= -66'sh80000000 && fxs <= 66'sh7FFFFFFF &&
             fys >= -66'sh80000000 && fys <= 66'sh7FFFFFFF;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_supported   <= fin_ok;
      out_dest_left   <= fin_ok ? bb_t2_r[BBX-1 -: COEF_W] : '0;
      out_dest_top    <= fin_ok ? bb_t2_r[BBX-1-COEF_W -: COEF_W] : '0;
      out_dest_width  <= fin_ok ? bb_t2_r[2*DIM_W -: DIM_W] : '0;
      out_dest_height <= fin_ok ? bb_t2_r[DIM_W:1] : '0;
      out_inv_xx      <= fin_ok ? t2_r[0] : '0;
      out_inv_xy      <= fin_ok ? t2_r[1] : '0;
      out_inv_yx      <= fin_ok ? t2_r[2] : '0;
      out_inv_yy      <= fin_ok ? t2_r[3] : '0;
      out_inv_xt      <= fin_ok ? COEF_W'(fxs) : '0;
      out_inv_yt      <= fin_ok ? COEF_W'(fys) : '0;
    end
  end

`ifndef NO_ASSERTIONS
  // unsupported results carry all-zero fields
  a_zero_when_unsup: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_supported |-> out_dest_width == '0 && out_inv_xx == '0)
    else $error("unsupported result with nonzero fields");
  // supported results never describe an empty rectangle
  a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_supported |-> out_dest_width != '0 && out_dest_height != '0)
    else $error("supported result with empty rectangle");
  // a stall holds the pipeline contents
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(vld_r))
    else $error("pipeline moved during stall");
`endif
endmodule
